>>> design/assert_macros.svh
// Assertion macros used by the design module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked from the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/rsrc_pkg.sv
package rsrc_pkg;

   localparam int POS_BITS = 64;
   localparam int SIZE_LOG2_MIN = 8;
   localparam logic [4:0] SIZE_LOG2_RESET = 5'd8;

   typedef enum logic [1:0] {
      MODE_RESERVE = 2'd0,
      MODE_COMMIT  = 2'd1,
      MODE_CANCEL  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_RANGE    = 3'd1,
      STATUS_PRECOND  = 3'd2,
      STATUS_LOSS     = 3'd3,
      STATUS_UNAVAIL  = 3'd4
   } status_type;

   localparam logic CSR_RING_SIZE_LOG2 = 1'b0;
   localparam logic CSR_START_POSITION = 1'b1;

endpackage

>>> design/ring_span_reserve_commit.sv
// An accepted item waits in the input register and moves to the result register when
// the output is free, so one item per cycle passes while the output is not stalled.
// Both registers form a two-stage path; committed position and reserved size update.
// Reset is synchronous and active high: the ring size exponent returns to 8, the
// committed position and reserved size clear, and both stages empty.
`include "assert_macros.svh"

module ring_span_reserve_commit
   import rsrc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_mode,
   input  logic [31:0]         req_span_bytes,
   input  logic [POS_BITS-1:0] req_read_position,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [30:0]         rsp_span_offset,
   output logic [30:0]         rsp_pad_offset,
   output logic [30:0]         rsp_pad_bytes,
   output logic                rsp_publish_valid,
   output logic [POS_BITS-1:0] rsp_publish_position,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [63:0]         csr_data
);

   logic                in_valid_ff;
   logic [1:0]          mode_ff;
   logic [31:0]         span_ff;
   logic [POS_BITS-1:0] read_ff;

   logic [4:0]          size_log2_ff;
   logic [POS_BITS-1:0] committed_ff;
   logic [POS_BITS-1:0] committed_in;
   logic [30:0]         reserved_ff;
   logic [30:0]         reserved_in;

   logic                out_valid_ff;
   logic [2:0]          status_ff;
   logic [2:0]          status_in;
   logic [30:0]         span_off_ff;
   logic [30:0]         span_off_in;
   logic [30:0]         pad_off_ff;
   logic [30:0]         pad_off_in;
   logic [30:0]         pad_len_ff;
   logic [30:0]         pad_len_in;
   logic                pub_valid_ff;
   logic                pub_valid_in;
   logic [POS_BITS-1:0] pub_pos_ff;
   logic [POS_BITS-1:0] pub_pos_in;

   logic                advance;
   logic                fire;
   logic                csr_write;

   logic [4:0]          size_exp;
   logic [31:0]         cap;
   logic [31:0]         cap_mask;
   logic [POS_BITS-1:0] diff;
   logic [31:0]         diff_lo;
   logic [30:0]         off;
   logic [31:0]         room;
   logic [31:0]         pad;
   logic [32:0]         need;
   logic [POS_BITS:0]   end_sum;
   logic [POS_BITS-1:0] w_pad;
   logic                bad_span;
   logic                bad_read;
   logic                pad_full;
   logic                span_full;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign size_exp = (size_log2_ff < 5'(SIZE_LOG2_MIN)) ? 5'(SIZE_LOG2_MIN) : size_log2_ff;
   assign cap      = 32'd1 << size_exp;
   assign cap_mask = cap - 32'd1;
   assign diff     = committed_ff - read_ff;
   assign diff_lo  = diff[31:0];
   assign off      = committed_ff[30:0] & cap_mask[30:0];
   assign room     = cap - {1'b0, off};
   assign pad      = (span_ff > room) ? room : 32'd0;
   assign need     = {1'b0, pad} + {1'b0, span_ff};
   assign end_sum  = {1'b0, committed_ff} + {{(POS_BITS-32){1'b0}}, need};
   assign w_pad    = committed_ff + {{(POS_BITS-32){1'b0}}, pad};

   assign bad_span  = (span_ff == 32'd0) || (span_ff[1:0] != 2'd0) || (span_ff >= cap);
   assign bad_read  = (read_ff[1:0] != 2'd0) || (read_ff > committed_ff)
                      || (diff >= {{(POS_BITS-32){1'b0}}, cap});
   assign pad_full  = (pad != 32'd0)
                      && (({1'b0, diff_lo} + {1'b0, pad}) >= {1'b0, cap});
   assign span_full = ({2'b0, diff_lo} + {2'b0, pad} + {2'b0, span_ff}) >= {2'b0, cap};

   always_comb begin
      committed_in = committed_ff;
      reserved_in  = reserved_ff;
      status_in    = STATUS_OK;
      span_off_in  = 31'd0;
      pad_off_in   = 31'd0;
      pad_len_in   = 31'd0;
      pub_valid_in = 1'b0;
      pub_pos_in   = '0;
      case (mode_ff)
         MODE_RESERVE: begin
            if (bad_span) begin
               status_in = STATUS_RANGE;
            end else if (reserved_ff != 31'd0) begin
               status_in = STATUS_PRECOND;
            end else if (bad_read) begin
               status_in = STATUS_LOSS;
            end else if (end_sum[POS_BITS]) begin
               status_in = STATUS_RANGE;
            end else if (pad_full) begin
               status_in = STATUS_UNAVAIL;
            end else begin
               if (pad != 32'd0) begin
                  pad_off_in   = off;
                  pad_len_in   = pad[30:0];
                  committed_in = w_pad;
                  pub_valid_in = 1'b1;
                  pub_pos_in   = w_pad;
               end
               if (span_full) begin
                  status_in = STATUS_UNAVAIL;
               end else begin
                  reserved_in = span_ff[30:0];
                  span_off_in = (pad != 32'd0) ? 31'd0 : off;
               end
            end
         end
         MODE_COMMIT: begin
            if (reserved_ff == 31'd0) begin
               status_in = STATUS_PRECOND;
            end else begin
               committed_in = committed_ff + {{(POS_BITS-31){1'b0}}, reserved_ff};
               reserved_in  = 31'd0;
               pub_valid_in = 1'b1;
               pub_pos_in   = committed_ff + {{(POS_BITS-31){1'b0}}, reserved_ff};
            end
         end
         MODE_CANCEL: begin
            reserved_in = 31'd0;
         end
         default: begin
            status_in = STATUS_RANGE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         size_log2_ff <= SIZE_LOG2_RESET;
         committed_ff <= '0;
         reserved_ff  <= 31'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (csr_write && csr_index == CSR_RING_SIZE_LOG2) begin
            size_log2_ff <= csr_data[4:0];
         end
         if (csr_write && csr_index == CSR_START_POSITION) begin
            committed_ff <= csr_data[POS_BITS-1:0];
            reserved_ff  <= 31'd0;
         end else if (fire) begin
            committed_ff <= committed_in;
            reserved_ff  <= reserved_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         mode_ff <= req_mode;
         span_ff <= req_span_bytes;
         read_ff <= req_read_position;
      end
      if (fire) begin
         status_ff    <= status_in;
         span_off_ff  <= span_off_in;
         pad_off_ff   <= pad_off_in;
         pad_len_ff   <= pad_len_in;
         pub_valid_ff <= pub_valid_in;
         pub_pos_ff   <= pub_pos_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_span_offset      = span_off_ff;
   assign rsp_pad_offset       = pad_off_ff;
   assign rsp_pad_bytes        = pad_len_ff;
   assign rsp_publish_valid    = pub_valid_ff;
   assign rsp_publish_position = pub_pos_ff;

   `ASSERT_CLK(a_pad_publishes, !rsp_valid || rsp_pad_bytes == 31'd0 || rsp_publish_valid, "pad reported without a publish")
   `ASSERT_CLK(a_offset_only_ok, !rsp_valid || rsp_status == STATUS_OK || rsp_span_offset == 31'd0, "span offset on a failed item")
   `ASSERT_NEXT(a_state_holds, !fire && !csr_write, $stable(committed_ff) && $stable(reserved_ff), "ring state changed without an item")

endmodule
